### design/integer_to_base_digits_top_macros.svh
// Assertion macros shared by the checker of integer_to_base_digits_top.
// Depends on nothing; every macro expects clk and rst_n in scope.
`ifndef INTEGER_TO_BASE_DIGITS_TOP_MACROS_SVH
`define INTEGER_TO_BASE_DIGITS_TOP_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ITOB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ITOB_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### design/itob_pkg.sv
// Shared types, constants and the digit-to-character function of the
// integer-to-text block. No dependencies.
package itob_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int BASE_WIDTH  = 8;
    localparam int CHAR_WIDTH  = 7;
    localparam int MIN_RADIX   = 2;
    localparam int MAX_RADIX   = 36;
    localparam int RADIX_WIDTH = $clog2(MAX_RADIX + 1);

    // Restoring division: this many quotient bits per clock.
    localparam int STEP_BITS  = 8;
    localparam int DIV_CYCLES = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_WIDTH  = DIV_CYCLES * STEP_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

    // Digit stack: one entry per possible digit (base 2 gives VALUE_WIDTH).
    localparam int DIG_IDX_W = $clog2(VALUE_WIDTH);
    localparam int DIG_CNT_W = $clog2(VALUE_WIDTH + 1);

    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_A     = 7'h61;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 7'h2d;
    localparam logic [CHAR_WIDTH-1:0] CHAR_NONE  = 7'h00;
    localparam logic [RADIX_WIDTH-1:0] DECIMAL_DIGITS = RADIX_WIDTH'(10);

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] value;
        logic [BASE_WIDTH-1:0]         base;
    } itob_in_t;

    typedef struct packed {
        logic [CHAR_WIDTH-1:0] digit_char;
        logic                  last;
        logic                  bad_base;
    } itob_out_t;

    function automatic logic [CHAR_WIDTH-1:0] char_of(input logic [RADIX_WIDTH-1:0] d);
        logic [CHAR_WIDTH-1:0] dw;
        dw = CHAR_WIDTH'(d);
        if (d < DECIMAL_DIGITS)
        begin
            return CHAR_ZERO + dw;
        end
        return CHAR_A + dw - CHAR_WIDTH'(DECIMAL_DIGITS);
    endfunction

endpackage

### design/itob_div.sv
// Iterative restoring divider: unsigned dividend by a small radix,
// STEP_BITS quotient bits per clock. Depends on itob_pkg.
module itob_div (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [itob_pkg::VALUE_WIDTH-1:0]       dividend,
    input  logic [itob_pkg::RADIX_WIDTH-1:0]       divisor,
    output logic                                   done,
    output logic [itob_pkg::VALUE_WIDTH-1:0]       quotient,
    output logic [itob_pkg::RADIX_WIDTH-1:0]       remainder
);

    localparam int RW = itob_pkg::RADIX_WIDTH;
    localparam int PW = itob_pkg::PAD_WIDTH;
    localparam int CW = itob_pkg::DIV_CNT_W;

    logic [PW-1:0] q_reg, q_next;
    logic [RW-1:0] r_reg, r_next;
    logic [RW-1:0] div_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [RW:0]   trial;

    // STEP_BITS shift/compare/subtract steps on the narrow remainder
    always_comb
    begin
        r_next = r_reg;
        q_next = q_reg;
        trial  = '0;
        for (int i = 0; i < itob_pkg::STEP_BITS; i++)
        begin
            trial  = {r_next, q_next[PW-1]};
            q_next = {q_next[PW-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                r_next    = RW'(trial - {1'b0, div_reg});
                q_next[0] = 1'b1;
            end
            else
            begin
                r_next = trial[RW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(itob_pkg::DIV_CYCLES - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= PW'(dividend);
            r_reg   <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg[itob_pkg::VALUE_WIDTH-1:0];
    assign remainder = r_reg;

endmodule

### design/integer_to_base_digits_top.sv
// Signed integer to ASCII text in radix 2..36, most significant char first.
// Digits are peeled off by repeated division, least significant first, then
// sent out one beat per cycle while out_ready allows, sign first.
// Throughput: one item at a time, set by the shared 8-bit-per-cycle divider.
// A bad base gives a single blank error beat.
// Reset: asynchronous, active low; returns to idle with the output empty.
module integer_to_base_digits_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  itob_pkg::itob_in_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output itob_pkg::itob_out_t out_data
);

    localparam int VW  = itob_pkg::VALUE_WIDTH;
    localparam int RW  = itob_pkg::RADIX_WIDTH;
    localparam int CHW = itob_pkg::CHAR_WIDTH;
    localparam int IW  = itob_pkg::DIG_IDX_W;
    localparam int NW  = itob_pkg::DIG_CNT_W;

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for an item
    localparam logic [1:0] ST_DIV  = 2'd1;  // peeling digits, least significant first
    localparam logic [1:0] ST_EMIT = 2'd2;  // sign, then digits popped off the stack
    localparam logic [1:0] ST_ERR  = 2'd3;  // single error beat pending

    logic [1:0]          state_reg, state_next;
    logic                neg_reg, neg_next;
    logic [RW-1:0]       base_reg;
    logic [NW-1:0]       cnt_reg, cnt_next;
    logic [CHW-1:0]      stack_reg [VW];
    logic                out_valid_reg, out_valid_next;
    itob_pkg::itob_out_t out_reg, out_next;

    logic          accept;
    logic          base_ok;
    logic [VW-1:0] value_u;
    logic [VW-1:0] mag;
    logic          div_start;
    logic [VW-1:0] div_dividend;
    logic [RW-1:0] div_divisor;
    logic          div_done;
    logic [VW-1:0] div_quot;
    logic [RW-1:0] div_rem;
    logic          push;
    logic          slot_free;
    logic [IW-1:0] rd_idx;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Radix is legal only within 2..MAX_RADIX
    assign base_ok = (in_data.base >= itob_pkg::BASE_WIDTH'(itob_pkg::MIN_RADIX))
                  && (in_data.base <= itob_pkg::BASE_WIDTH'(itob_pkg::MAX_RADIX));

    // Magnitude in unsigned arithmetic: the most negative value maps to 2^(VW-1)
    assign value_u = in_data.value;
    assign mag     = in_data.value[VW-1] ? (~value_u + VW'(1)) : value_u;

    // Start the divider on a fresh item with a legal base, or restart it on the quotient while it is nonzero
    assign push         = (state_reg == ST_DIV) && div_done;
    assign div_start    = (accept && base_ok) || (push && (div_quot != '0));
    assign div_dividend = accept ? mag : div_quot;
    assign div_divisor  = accept ? in_data.base[RW-1:0] : base_reg;

    itob_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Output register frees when empty or when its beat is taken this cycle
    assign slot_free = !out_valid_reg || out_ready;
    assign rd_idx    = IW'(cnt_reg - NW'(1));

    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next   = in_data.value[VW-1];
                    cnt_next   = '0;
                    state_next = base_ok ? ST_DIV : ST_ERR;
                end
            end
            ST_DIV:
            begin
                if (push)
                begin
                    cnt_next = cnt_reg + NW'(1);
                    if (div_quot == '0)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_next.bad_base = 1'b0;
                    if (neg_reg)
                    begin
                        out_next.digit_char = itob_pkg::CHAR_MINUS;
                        out_next.last       = 1'b0;
                        neg_next            = 1'b0;
                    end
                    else
                    begin
                        out_next.digit_char = stack_reg[rd_idx];
                        out_next.last       = (cnt_reg == NW'(1));
                        cnt_next            = cnt_reg - NW'(1);
                        if (cnt_reg == NW'(1))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_ERR:
            begin
                if (slot_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.digit_char = itob_pkg::CHAR_NONE;
                    out_next.last       = 1'b1;
                    out_next.bad_base   = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            neg_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            neg_reg       <= neg_next;
        end
    end

    // Payload: output beat, radix, digit stack
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (accept)
        begin
            base_reg <= in_data.base[RW-1:0];
        end
        if (push)
        begin
            stack_reg[cnt_reg[IW-1:0]] <= itob_pkg::char_of(div_rem);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### design/itob_checker.sv
// Port-level checker for integer_to_base_digits_top, bound to the top level.
// Depends on itob_pkg and integer_to_base_digits_top_macros.svh.
`include "integer_to_base_digits_top_macros.svh"

module itob_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input itob_pkg::itob_out_t out_data
);

    // Hold a stalled output beat
    `ITOB_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled output beat changed")

    // Error beat is alone and blank
    `ITOB_ASSERT(a_err_beat, out_valid && out_data.bad_base |-> out_data.last && out_data.digit_char == itob_pkg::CHAR_NONE, "malformed error beat")

    // One item at a time: busy right after an accept
    `ITOB_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "ready right after accept")

    // No new item while a conversion is still mid-string
    `ITOB_NEVER(a_no_accept_mid_string, out_valid && !out_data.last && in_ready, "ready during emission")

endmodule

bind integer_to_base_digits_top itob_checker u_itob_checker (.*);

### tb/sv/tb_integer_to_base_digits_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for integer_to_base_digits_top: random and directed
// integer/radix items in, ASCII characters out. Depends on itob_pkg and integer_to_base_digits_top.
module tb_integer_to_base_digits_top;

    import itob_pkg::*;

    // Run length and pacing
    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 10;
    localparam int RANDOM_ITEMS  = 100;
    localparam int CYCLE_LIMIT   = 1_000_000;
    // Drain past the slowest conversion (base 2, 33 chars).
    localparam int DRAIN_CYCLES  = 300;
    // Receiver hold-off: long enough for the block to fill and stall its input.
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_SPACING  = 60;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    itob_in_t   in_data   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    itob_out_t  out_data;

    // Items waiting to be offered, and characters waiting to come out.
    itob_in_t   pending_items[$];
    itob_out_t  expected_chars[$];

    logic       in_fire = 1'b0;
    int         items_in = 0;
    int         mismatch_count = 0;
    longint     cycle_count = 0;

    // Idle bookkeeping, one set per side.
    int         send_gap = 0;
    int         send_calm = 0;
    int         recv_stall = 0;
    int         recv_calm = 0;
    int         hold_left = 0;
    int         next_hold_at = 30;

    integer_to_base_digits_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // Gap length for either side: mostly none or short, now and then long.
    // A calm stretch forces a run of back-to-back beats.
    function automatic int pick_gap(inout int calm);
        int roll;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 5)
        begin
            calm = $urandom_range(15, 40);
            return 0;
        end
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic void push_char(logic [CHAR_WIDTH-1:0] ch, logic is_last, logic is_bad);
        itob_out_t r;
        r.digit_char = ch;
        r.last       = is_last;
        r.bad_base   = is_bad;
        expected_chars.push_back(r);
    endfunction

    // Predict the character stream of one conversion and queue it.
    function automatic void predict_text(itob_in_t item);
        logic [VALUE_WIDTH-1:0] magnitude;
        logic [VALUE_WIDTH-1:0] radix;
        logic [VALUE_WIDTH-1:0] remainder;
        logic [CHAR_WIDTH-1:0]  digit_text[$];
        logic                   negative;
        if (item.base < MIN_RADIX || item.base > MAX_RADIX)
        begin
            push_char(CHAR_NONE, 1'b1, 1'b1);
            return;
        end
        radix    = VALUE_WIDTH'(item.base);
        negative = item.value[VALUE_WIDTH-1];
        // Negate in unsigned arithmetic so the most negative value stays exact.
        magnitude = negative ? (~item.value + 1'b1) : item.value;
        do
        begin
            remainder = magnitude % radix;
            if (remainder < 10)
                digit_text.push_front(CHAR_ZERO + CHAR_WIDTH'(remainder));
            else
                digit_text.push_front(CHAR_A + CHAR_WIDTH'(remainder - 10));
            magnitude = magnitude / radix;
        end
        while (magnitude != 0);
        if (negative)
            push_char(CHAR_MINUS, 1'b0, 1'b0);
        foreach (digit_text[i])
            push_char(digit_text[i], i == digit_text.size() - 1, 1'b0);
    endfunction

    function automatic void queue_item(logic signed [VALUE_WIDTH-1:0] v, logic [BASE_WIDTH-1:0] b);
        itob_in_t item;
        item.value = v;
        item.base  = b;
        pending_items.push_back(item);
    endfunction

    // Value mix: short values give short strings, full-width ones stress the
    // divider, and a few sit at the extremes.
    function automatic logic signed [VALUE_WIDTH-1:0] random_value();
        logic [VALUE_WIDTH-1:0] v;
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1: v = $urandom_range(0, 999);
            2: v = $urandom >> $urandom_range(0, VALUE_WIDTH - 1);
            3: v = -($urandom >> $urandom_range(0, VALUE_WIDTH - 1));
            default: v = $urandom_range(0, 1) ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
                                              : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
        endcase
        return v;
    endfunction

    // Bases: mostly legal, weighted toward the common radixes; some rejected.
    function automatic logic [BASE_WIDTH-1:0] random_base();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return BASE_WIDTH'($urandom_range(0, 1));
        if (roll < 20)
            return BASE_WIDTH'($urandom_range(MAX_RADIX + 1, 255));
        if (roll < 30)
            return BASE_WIDTH'(MIN_RADIX);
        if (roll < 40)
            return BASE_WIDTH'(10);
        if (roll < 45)
            return BASE_WIDTH'(16);
        return BASE_WIDTH'($urandom_range(MIN_RADIX, MAX_RADIX));
    endfunction

    // Stimulus, reset and end of run.
    initial
    begin
        // Zero in base 10 and the extreme radixes
        queue_item(0, 10);
        queue_item(0, MIN_RADIX);
        queue_item(0, MAX_RADIX);
        // Most negative value: magnitude must come out exact
        queue_item({1'b1, {(VALUE_WIDTH-1){1'b0}}}, MIN_RADIX);
        queue_item({1'b1, {(VALUE_WIDTH-1){1'b0}}}, 10);
        queue_item({1'b1, {(VALUE_WIDTH-1){1'b0}}}, 16);
        queue_item({1'b1, {(VALUE_WIDTH-1){1'b0}}}, MAX_RADIX);
        // Most positive value (longest positive string in base 2), then most negative plus one
        queue_item({1'b0, {(VALUE_WIDTH-1){1'b1}}}, MIN_RADIX);
        queue_item({1'b0, {(VALUE_WIDTH-1){1'b1}}}, MAX_RADIX);
        queue_item({1'b1, {(VALUE_WIDTH-2){1'b0}}, 1'b1}, 10);
        // All-ones value
        queue_item(-1, MIN_RADIX);
        queue_item(-1, 10);
        // Letter digits at both ends of the alphabet, then mixed values and radixes
        queue_item(35, MAX_RADIX);
        queue_item(1295, MAX_RADIX);
        queue_item(10, 11);
        queue_item(-255, 16);
        queue_item(123456789, 10);
        queue_item(-1000, 3);
        queue_item(1, 37 - 1);
        // Rejected radixes, including just past the top and all-ones
        queue_item(5, 0);
        queue_item(5, 1);
        queue_item(-5, MAX_RADIX + 1);
        queue_item(-1, 8'hff);
        queue_item(42, 8'h80);
        repeat (RANDOM_ITEMS)
            queue_item(random_value(), random_base());

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Wait for every item to be taken and every character to come out.
        while (pending_items.size() != 0 || in_valid || expected_chars.size() != 0)
            @(posedge clk);
        // Give a stray extra character time to show up.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_chars.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Input driver: offer the next item once the previous beat went through,
    // with random gaps between items. Hold valid and payload until accepted.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_fire)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                in_data  <= pending_items.pop_front();
                in_valid <= 1'b1;
                send_gap = pick_gap(send_calm);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output side ready: random stalls, plus a long hold-off every so many
    // accepted items while the driver keeps offering, so the input backs up.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (items_in >= next_hold_at)
            begin
                hold_left = HOLD_CYCLES;
                next_hold_at += HOLD_SPACING;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    recv_stall = pick_gap(recv_calm);
            end
        end
    end

    // Monitor: predict on each input beat, check each output beat against
    // the oldest expected character, field by field.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_fire <= 1'b0;
        end
        else
        begin
            in_fire <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                predict_text(in_data);
                items_in++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected output beat: digit_char %h last %b bad_base %b",
                           out_data.digit_char, out_data.last, out_data.bad_base);
                    mismatch_count++;
                end
                else
                begin
                    if (out_data.digit_char !== expected_chars[0].digit_char)
                    begin
                        $error("digit_char: expected %h, got %h",
                               expected_chars[0].digit_char, out_data.digit_char);
                        mismatch_count++;
                    end
                    if (out_data.last !== expected_chars[0].last)
                    begin
                        $error("last: expected %b, got %b",
                               expected_chars[0].last, out_data.last);
                        mismatch_count++;
                    end
                    if (out_data.bad_base !== expected_chars[0].bad_base)
                    begin
                        $error("bad_base: expected %b, got %b",
                               expected_chars[0].bad_base, out_data.bad_base);
                        mismatch_count++;
                    end
                    void'(expected_chars.pop_front());
                end
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule
